// ----- src/dipb_pkg.sv -----
`timescale 1ns / 1ps

package dipb_pkg;

    // stream and configuration port widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IW_GAINS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BWA_GAINS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPD_GAINS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IW_SP      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BW_SP      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_MAX   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_MIN   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_EN    = 3'd7;

    // microprogram counter width and jump targets
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] ST_BW_UPD = 5'd10;
    localparam logic [PC_W-1:0] ST_IW     = 5'd11;
    localparam logic [PC_W-1:0] ST_OFF    = 5'd17;
    localparam logic [PC_W-1:0] ST_DONE   = 5'd18;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ERR,
        OP_MUL,
        OP_DELTA,
        OP_UPD,
        OP_CLEAR,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        LP_BW,
        LP_SPD,
        LP_IW
    } loop_t;

    typedef enum logic [1:0] {
        TM_P,
        TM_I,
        TM_D
    } term_t;

    typedef enum logic [2:0] {
        CD_NEXT,
        CD_ALWAYS,
        CD_NO_DRIVE,
        CD_NO_BW,
        CD_NO_SPD,
        CD_NO_IW
    } cond_t;

    typedef struct packed {
        op_t              op;
        loop_t            lp;
        term_t            term;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } ctrl_word_t;

    typedef struct packed {
        logic drive;
        logic bw_en;
        logic spd_en;
        logic iw_en;
    } cond_flags_t;

    function automatic ctrl_word_t mk(
        input op_t             op,
        input loop_t           lp,
        input term_t           tm,
        input cond_t           cd,
        input logic [PC_W-1:0] tgt,
        input logic            last
    );
        ctrl_word_t w;
        w.op     = op;
        w.lp     = lp;
        w.term   = tm;
        w.cond   = cd;
        w.target = tgt;
        w.last   = last;
        return w;
    endfunction

    // control store: three products per loop through one multiplier
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            5'd0:    w = mk(OP_ERR,   LP_BW,  TM_P, CD_NO_DRIVE, ST_OFF,    1'b0);
            5'd1:    w = mk(OP_MUL,   LP_BW,  TM_P, CD_NO_BW,    ST_IW,     1'b0);
            5'd2:    w = mk(OP_MUL,   LP_BW,  TM_I, CD_NEXT,     ST_DONE,   1'b0);
            5'd3:    w = mk(OP_MUL,   LP_BW,  TM_D, CD_NEXT,     ST_DONE,   1'b0);
            5'd4:    w = mk(OP_DELTA, LP_BW,  TM_P, CD_NO_SPD,   ST_BW_UPD, 1'b0);
            5'd5:    w = mk(OP_ERR,   LP_SPD, TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd6:    w = mk(OP_MUL,   LP_SPD, TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd7:    w = mk(OP_MUL,   LP_SPD, TM_I, CD_NEXT,     ST_DONE,   1'b0);
            5'd8:    w = mk(OP_MUL,   LP_SPD, TM_D, CD_NEXT,     ST_DONE,   1'b0);
            5'd9:    w = mk(OP_DELTA, LP_SPD, TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd10:   w = mk(OP_UPD,   LP_BW,  TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd11:   w = mk(OP_ERR,   LP_IW,  TM_P, CD_NO_IW,    ST_DONE,   1'b0);
            5'd12:   w = mk(OP_MUL,   LP_IW,  TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd13:   w = mk(OP_MUL,   LP_IW,  TM_I, CD_NEXT,     ST_DONE,   1'b0);
            5'd14:   w = mk(OP_MUL,   LP_IW,  TM_D, CD_NEXT,     ST_DONE,   1'b0);
            5'd15:   w = mk(OP_DELTA, LP_IW,  TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd16:   w = mk(OP_UPD,   LP_IW,  TM_P, CD_ALWAYS,   ST_DONE,   1'b0);
            5'd17:   w = mk(OP_CLEAR, LP_BW,  TM_P, CD_NEXT,     ST_DONE,   1'b0);
            5'd18:   w = mk(OP_OUT,   LP_BW,  TM_P, CD_NEXT,     ST_DONE,   1'b1);
            default: w = mk(OP_NOP,   LP_BW,  TM_P, CD_ALWAYS,   ST_DONE,   1'b0);
        endcase
        return w;
    endfunction

endpackage

// ----- src/dipb_sequencer.sv -----
`timescale 1ns / 1ps

module dipb_sequencer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     hold,
    input  dipb_pkg::cond_flags_t    flags,
    output logic                     busy,
    output dipb_pkg::ctrl_word_t     ctrl
);
    import dipb_pkg::*;

    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = ucode(pc_reg);
    assign busy = busy_reg;

    // jump condition decode
    always_comb
    begin
        unique case (ctrl.cond)
            CD_NEXT:     take = 1'b0;
            CD_ALWAYS:   take = 1'b1;
            CD_NO_DRIVE: take = !flags.drive;
            CD_NO_BW:    take = !flags.bw_en;
            CD_NO_SPD:   take = !flags.spd_en;
            CD_NO_IW:    take = !flags.iw_en;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end
        else if (!hold)
        begin
            if (ctrl.last)
                busy_next = 1'b0;
            else if (take)
                pc_next = ctrl.target;
            else
                pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

// ----- src/dual_incremental_pid_balance_unit.sv -----
`timescale 1ns / 1ps

// dual incremental pid balance unit: each input transaction carries the bottom
// wheel and inertia wheel tilt angles (q8.8), the encoder count of the tick
// and a drive enable; each one yields exactly one output transaction with both
// saturated duty accumulators (q15.8). a small microprogram steps one shared
// 16 x n multiplier through the kp, ki and kd products of each active loop
// (bottom angle loop, optional speed cascade, inertia loop), one control word
// per cycle while the result step is not held by a full output register. the
// input is ready only while the sequencer is idle, so a new transaction is
// taken only after the last one has loaded its result into the output
// register. a finished result waits in the output register while the next
// transaction is already being worked on. configuration registers are written
// only while the unit is idle, a rule for the user that the unit does not enforce.
module dual_incremental_pid_balance_unit #(
    parameter int FRAC_BITS  = 8,
    parameter int DUTY_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [dipb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dipb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bw_angle[15:0], iw_angle[31:16], encoder_count[47:32], drive_enable[48]
    input  logic [dipb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bw_duty[23:0], iw_duty[47:24]
    output logic [dipb_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import dipb_pkg::*;

    // error width covers the speed loop error, the widest of the three
    localparam int EW  = ((DUTY_WIDTH - FRAC_BITS > 16) ? DUTY_WIDTH - FRAC_BITS : 16) + 1;
    localparam int TW  = EW + 2;           // multiplier term
    localparam int PW  = TW + 16;          // product
    localparam int SW  = PW + 2;           // sum of three products
    localparam int CW  = (DUTY_WIDTH + 1 > 25) ? DUTY_WIDTH + 1 : 25;
    localparam int OW  = (DUTY_WIDTH > 24) ? DUTY_WIDTH : 24;
    localparam int DW1 = DUTY_WIDTH + 1;

    localparam logic signed [SW-1:0] SAT_HI =
        SW'((64'sd1 <<< (DUTY_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [DW1-1:0] TRUNC_BIAS = DW1'((64'd1 << FRAC_BITS) - 64'd1);

    function automatic logic signed [DUTY_WIDTH-1:0] sat_duty(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] r;
        r = v;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        return r[DUTY_WIDTH-1:0];
    endfunction

    // configuration registers
    logic [47:0]        iw_gains_reg;
    logic [47:0]        bwa_gains_reg;
    logic [47:0]        spd_gains_reg;
    logic signed [15:0] iw_sp_reg;
    logic signed [15:0] bw_sp_reg;
    logic [22:0]        duty_max_reg;
    logic signed [23:0] duty_min_reg;
    logic [2:0]         loop_en_reg;

    // latched input transaction
    logic signed [15:0] bw_angle_reg;
    logic signed [15:0] iw_angle_reg;
    logic signed [15:0] enc_reg;
    logic               drive_reg;

    // datapath registers
    logic signed [EW-1:0]         err_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [SW-1:0]         sum_reg;
    logic signed [DUTY_WIDTH-1:0] delta_reg;

    // loop state
    logic signed [16:0]           bw_h0_reg;
    logic signed [16:0]           bw_h1_reg;
    logic signed [16:0]           iw_h0_reg;
    logic signed [16:0]           iw_h1_reg;
    logic signed [EW-1:0]         sp_h0_reg;
    logic signed [EW-1:0]         sp_h1_reg;
    logic signed [DUTY_WIDTH-1:0] bw_acc_reg;
    logic signed [DUTY_WIDTH-1:0] iw_acc_reg;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [23:0] out_bw_reg;
    logic [23:0] out_iw_reg;

    // sequencer interface
    logic        accept;
    logic        busy;
    logic        hold;
    logic        exec;
    ctrl_word_t  ctrl;
    cond_flags_t flags;

    // datapath combinational signals
    logic [47:0]                  gains_sel;
    logic signed [EW-1:0]         h0_sel;
    logic signed [EW-1:0]         h1_sel;
    logic signed [EW-1:0]         err_new;
    logic signed [15:0]           gain_sel;
    logic signed [TW-1:0]         term_sel;
    logic signed [TW-1:0]         t_p;
    logic signed [TW-1:0]         t_i;
    logic signed [TW-1:0]         t_d;
    logic signed [PW-1:0]         prod_mul;
    logic signed [SW-1:0]         total;
    logic signed [SW-1:0]         delta_raw;
    logic signed [DUTY_WIDTH-1:0] delta_sat;
    logic signed [DW1-1:0]        trunc_sum;
    logic signed [DW1-1:0]        trunc_q;
    logic signed [DUTY_WIDTH-1:0] acc_sel;
    logic signed [CW-1:0]         upd_sum;
    logic signed [CW-1:0]         lim_hi;
    logic signed [CW-1:0]         lim_lo;
    logic signed [CW-1:0]         lim_val;
    logic signed [DUTY_WIDTH-1:0] upd_val;
    logic signed [OW-1:0]         bw_acc_ext;
    logic signed [OW-1:0]         iw_acc_ext;

    // handshakes
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_iw_reg, out_bw_reg};

    // only the result step can stall, when the output register is still full
    assign hold = busy && (ctrl.op == OP_OUT) && out_valid_reg && !m_axis_tready;
    assign exec = busy && !hold;

    assign flags.drive  = drive_reg;
    assign flags.bw_en  = loop_en_reg[0];
    assign flags.spd_en = loop_en_reg[1];
    assign flags.iw_en  = loop_en_reg[2];

    dipb_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .hold  (hold),
        .flags (flags),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // speed error: angle delta truncated toward zero to an integer
    assign trunc_sum = DW1'(delta_reg) + (delta_reg[DUTY_WIDTH-1] ? signed'(TRUNC_BIAS) : '0);
    assign trunc_q   = trunc_sum >>> FRAC_BITS;

    // per-loop operand select
    always_comb
    begin
        unique case (ctrl.lp)
            LP_BW:
            begin
                gains_sel = bwa_gains_reg;
                h0_sel    = EW'(bw_h0_reg);
                h1_sel    = EW'(bw_h1_reg);
                err_new   = EW'(bw_sp_reg) - EW'(bw_angle_reg);
            end
            LP_SPD:
            begin
                gains_sel = spd_gains_reg;
                h0_sel    = sp_h0_reg;
                h1_sel    = sp_h1_reg;
                err_new   = EW'(trunc_q) - EW'(enc_reg);
            end
            LP_IW:
            begin
                gains_sel = iw_gains_reg;
                h0_sel    = EW'(iw_h0_reg);
                h1_sel    = EW'(iw_h1_reg);
                err_new   = EW'(iw_angle_reg) - EW'(iw_sp_reg);
            end
            default:
            begin
                gains_sel = '0;
                h0_sel    = '0;
                h1_sel    = '0;
                err_new   = '0;
            end
        endcase
    end

    // incremental pid terms: e - e1, e, e + e2 - 2*e1
    assign t_p = TW'(err_reg) - TW'(h0_sel);
    assign t_i = TW'(err_reg);
    assign t_d = TW'(err_reg) + TW'(h1_sel) - (TW'(h0_sel) <<< 1);

    always_comb
    begin
        unique case (ctrl.term)
            TM_P:
            begin
                gain_sel = signed'(gains_sel[47:32]);
                term_sel = t_p;
            end
            TM_I:
            begin
                gain_sel = signed'(gains_sel[31:16]);
                term_sel = t_i;
            end
            TM_D:
            begin
                gain_sel = signed'(gains_sel[15:0]);
                term_sel = t_d;
            end
            default:
            begin
                gain_sel = '0;
                term_sel = '0;
            end
        endcase
    end

    // shared multiplier, registered before the accumulate
    assign prod_mul = gain_sel * term_sel;
    assign total    = sum_reg + SW'(prod_reg);

    // angle loops drop the fraction of the q.2f sum, the speed loop is already q.f
    assign delta_raw = (ctrl.lp == LP_SPD) ? total : (total >>> FRAC_BITS);
    assign delta_sat = sat_duty(delta_raw);

    // accumulator update: upper limit wins over lower limit
    assign acc_sel = (ctrl.lp == LP_IW) ? iw_acc_reg : bw_acc_reg;
    assign upd_sum = CW'(acc_sel) + CW'(delta_reg);
    assign lim_hi  = CW'(signed'({1'b0, duty_max_reg}));
    assign lim_lo  = CW'(duty_min_reg);

    always_comb
    begin
        if (upd_sum > lim_hi)
            lim_val = lim_hi;
        else if (upd_sum < lim_lo)
            lim_val = lim_lo;
        else
            lim_val = upd_sum;
    end

    assign upd_val    = sat_duty(SW'(lim_val));
    assign bw_acc_ext = OW'(bw_acc_reg);
    assign iw_acc_ext = OW'(iw_acc_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_gains_reg  <= 48'h0A00_0000_0000;
            bwa_gains_reg <= 48'h0333_0000_0000;
            spd_gains_reg <= 48'h0100_0000_0000;
            iw_sp_reg     <= '0;
            bw_sp_reg     <= '0;
            duty_max_reg  <= 23'd25600;
            duty_min_reg  <= -24'sd25600;
            loop_en_reg   <= 3'b111;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_IW_GAINS:  iw_gains_reg  <= cfg_wdata;
                CFG_BWA_GAINS: bwa_gains_reg <= cfg_wdata;
                CFG_SPD_GAINS: spd_gains_reg <= cfg_wdata;
                CFG_IW_SP:     iw_sp_reg     <= signed'(cfg_wdata[15:0]);
                CFG_BW_SP:     bw_sp_reg     <= signed'(cfg_wdata[15:0]);
                CFG_DUTY_MAX:  duty_max_reg  <= cfg_wdata[22:0];
                CFG_DUTY_MIN:  duty_min_reg  <= signed'(cfg_wdata[23:0]);
                CFG_LOOP_EN:   loop_en_reg   <= cfg_wdata[2:0];
                default:       ;
            endcase
        end
    end

    // input latch and datapath payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bw_angle_reg <= signed'(s_axis_tdata[15:0]);
            iw_angle_reg <= signed'(s_axis_tdata[31:16]);
            enc_reg      <= signed'(s_axis_tdata[47:32]);
        end
        if (exec)
        begin
            case (ctrl.op)
                OP_ERR:
                    err_reg <= err_new;
                OP_MUL:
                begin
                    prod_reg <= prod_mul;
                    sum_reg  <= (ctrl.term == TM_P) ? '0 : total;
                end
                OP_DELTA:
                    delta_reg <= delta_sat;
                OP_OUT:
                begin
                    out_bw_reg <= bw_acc_ext[23:0];
                    out_iw_reg <= iw_acc_ext[23:0];
                end
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec && (ctrl.op == OP_OUT))
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // loop state: error histories, duty accumulators, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg     <= 1'b0;
            bw_h0_reg     <= '0;
            bw_h1_reg     <= '0;
            iw_h0_reg     <= '0;
            iw_h1_reg     <= '0;
            sp_h0_reg     <= '0;
            sp_h1_reg     <= '0;
            bw_acc_reg    <= '0;
            iw_acc_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                drive_reg <= s_axis_tdata[48];
            if (exec)
            begin
                case (ctrl.op)
                    OP_DELTA:
                    begin
                        case (ctrl.lp)
                            LP_BW:
                            begin
                                bw_h1_reg <= bw_h0_reg;
                                bw_h0_reg <= err_reg[16:0];
                            end
                            LP_SPD:
                            begin
                                sp_h1_reg <= sp_h0_reg;
                                sp_h0_reg <= err_reg;
                            end
                            LP_IW:
                            begin
                                iw_h1_reg <= iw_h0_reg;
                                iw_h0_reg <= err_reg[16:0];
                            end
                            default:
                                ;
                        endcase
                    end
                    OP_UPD:
                    begin
                        if (ctrl.lp == LP_IW)
                            iw_acc_reg <= upd_val;
                        else
                            bw_acc_reg <= upd_val;
                    end
                    OP_CLEAR:
                    begin
                        bw_acc_reg <= '0;
                        iw_acc_reg <= '0;
                    end
                    default:
                        ;
                endcase
            end
        end
    end

    // an accepted transaction always starts the microprogram
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("sequencer did not start on an accepted transaction");

    // the result step always fills the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        exec && (ctrl.op == OP_OUT) |=> out_valid_reg)
        else $error("result step did not load the output register");

    // loop state only moves while a transaction is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> $stable(bw_acc_reg) && $stable(iw_acc_reg) && $stable(bw_h0_reg)
                  && $stable(iw_h0_reg) && $stable(sp_h0_reg))
        else $error("loop state changed while idle");

endmodule
